/* hw/rtl/qpf_pkg.sv */
// Shared types, constants and helper functions for the QRS filter chain.
package qpf_pkg;

    // Word and sample widths.
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned SAMPLE_W = 12;

    // Length of the integration window, in samples (1 to 64).
    localparam int unsigned WINDOW_LENGTH = 30;

    // History depths and tap positions of the filters.
    localparam int unsigned RAW_DEPTH   = 12;
    localparam int unsigned RAW_MID_TAP = 5;
    localparam int unsigned RAW_END_TAP = 11;
    localparam int unsigned LP_DEPTH    = 32;
    localparam int unsigned LP_TAP_A    = 15;
    localparam int unsigned LP_TAP_B    = 16;
    localparam int unsigned LP_TAP_END  = 31;
    localparam int unsigned HP_DEPTH    = 4;

    // Shift amounts of the truncating divisions by 32 and by 8.
    localparam int unsigned SHIFT_DIV32 = 5;
    localparam int unsigned SHIFT_DIV8  = 3;

    // Pipeline depth; the last stage is the output register.
    localparam int unsigned NUM_STAGES = 12;

    // Window division: floor(2^31 / WINDOW_LENGTH) gives an estimate that is
    // at most one below the true quotient for any magnitude up to 2^31.
    localparam int unsigned MAGIC_SHIFT = 31;
    localparam logic [WORD_W-1:0] DIV_MAGIC =
        WORD_W'((64'd1 << MAGIC_SHIFT) / 64'(WINDOW_LENGTH));
    localparam logic [WORD_W-1:0] WINDOW_WORD = WORD_W'(WINDOW_LENGTH);
    localparam int unsigned REM_W = $clog2(2 * WINDOW_LENGTH);

    typedef logic signed [WORD_W-1:0]   t_word;
    typedef logic        [WORD_W-1:0]   t_uword;
    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic        [REM_W-1:0]    t_rem;

    // Signed division by 2^sh, truncated toward zero.
    function automatic t_word div_pow2_trunc(input t_word v, input int unsigned sh);
        t_word bias;
        bias = v[WORD_W-1] ? t_word'((64'd1 << sh) - 64'd1) : '0;
        return (v + bias) >>> sh;
    endfunction

endpackage

/* hw/rtl/qpf_sample_if.sv */
// Request channel that carries one raw ECG sample.
interface qpf_sample_if;
    import qpf_pkg::*;

    logic    valid;
    logic    ready;
    t_sample sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

/* hw/rtl/qpf_result_if.sv */
// Request channel that carries one integrated value.
interface qpf_result_if;
    import qpf_pkg::*;

    logic  valid;
    logic  ready;
    t_word integrated;

    modport source (output valid, output integrated, input ready);
    modport sink   (input valid, input integrated, output ready);
endinterface

/* hw/rtl/qrs_preprocess_filter_chain.sv */
// Top level of the QRS pre-processing filter chain: low-pass, high-pass, derivative, square, window mean.
//
//   Channel        Direction  Payload                 Meaning
//   i_sample       in         sample [11:0] signed    raw ECG sample, newest
//   o_result       out        integrated [31:0] sgn   window mean of squared derivative
//
// One request is taken every cycle while no waiting result holds the pipeline.
// The low-pass, high-pass and running-sum recursions each close inside one stage,
// which is what allows one sample per cycle.
// Reset (synchronous) empties the pipeline and clears every history cell to zero.
// When a result waits and is not taken, the whole pipeline holds and input is refused.
module qrs_preprocess_filter_chain (
    input  logic         i_clk,
    input  logic         i_rst_n,
    qpf_sample_if.sink   i_sample,
    qpf_result_if.source o_result
);
    import qpf_pkg::*;

    // Pipeline control.
    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] w_load;
    logic                  w_adv;

    assign w_adv = !r_vld[NUM_STAGES-1] || o_result.ready;
    assign w_load = {r_vld[NUM_STAGES-2:0], i_sample.valid} & {NUM_STAGES{w_adv}};
    assign i_sample.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NUM_STAGES-2:0], i_sample.valid};
        end
    end

    // Stage 0: raw sample history and the low-pass feed-forward term.
    t_sample r_raw [RAW_DEPTH];
    t_word   r_term;
    t_word   w_ff_sum;

    assign w_ff_sum = t_word'(i_sample.sample) - (t_word'(r_raw[RAW_MID_TAP]) <<< 1)
                    + t_word'(r_raw[RAW_END_TAP]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < RAW_DEPTH; k++) begin
                r_raw[k] <= '0;
            end
        end else if (w_load[0]) begin
            r_raw[0] <= i_sample.sample;
            for (int k = 1; k < RAW_DEPTH; k++) begin
                r_raw[k] <= r_raw[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load[0]) begin
            r_term <= div_pow2_trunc(w_ff_sum, SHIFT_DIV32);
        end
    end

    // Stage 1: low-pass recursion; r_lp1 is the newest low-pass value.
    t_word r_lp1;
    t_word r_lp2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp1 <= '0;
            r_lp2 <= '0;
        end else if (w_load[1]) begin
            r_lp1 <= (r_lp1 <<< 1) - r_lp2 + r_term;
            r_lp2 <= r_lp1;
        end
    end

    // Stage 2: low-pass history line and the high-pass feed-forward part.
    t_word w_lph_q [LP_DEPTH];
    t_word r_hp_part;

    for (genvar k = 0; k < LP_DEPTH; k++) begin : g_lph
        if (k == 0) begin : g_head
            qpf_tap_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_load[2]),
                .i_d     (r_lp1),
                .o_q     (w_lph_q[k])
            );
        end else begin : g_body
            qpf_tap_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_load[2]),
                .i_d     (w_lph_q[k-1]),
                .o_q     (w_lph_q[k])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load[2]) begin
            r_hp_part <= w_lph_q[LP_TAP_A] - w_lph_q[LP_TAP_B]
                       + div_pow2_trunc(w_lph_q[LP_TAP_END], SHIFT_DIV32)
                       - div_pow2_trunc(r_lp1, SHIFT_DIV32);
        end
    end

    // Stage 3: high-pass recursion; r_hp1 is the newest high-pass value.
    t_word r_hp1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hp1 <= '0;
        end else if (w_load[3]) begin
            r_hp1 <= r_hp1 + r_hp_part;
        end
    end

    // Stage 4: high-pass history line and the five-point derivative sum.
    t_word w_hph_q [HP_DEPTH];
    t_word r_dsum;

    for (genvar k = 0; k < HP_DEPTH; k++) begin : g_hph
        if (k == 0) begin : g_head
            qpf_tap_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_load[4]),
                .i_d     (r_hp1),
                .o_q     (w_hph_q[k])
            );
        end else begin : g_body
            qpf_tap_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_load[4]),
                .i_d     (w_hph_q[k-1]),
                .o_q     (w_hph_q[k])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load[4]) begin
            r_dsum <= (r_hp1 <<< 1) + w_hph_q[0] - w_hph_q[2] - (w_hph_q[3] <<< 1);
        end
    end

    // Stage 5: derivative divided by 8.
    t_word r_d;

    always_ff @(posedge i_clk) begin
        if (w_load[5]) begin
            r_d <= div_pow2_trunc(r_dsum, SHIFT_DIV8);
        end
    end

    // Stage 6: square, kept to the low word.
    logic signed [2*WORD_W-1:0] w_sq_full;
    t_word                      r_sq;

    assign w_sq_full = r_d * r_d;

    always_ff @(posedge i_clk) begin
        if (w_load[6]) begin
            r_sq <= w_sq_full[WORD_W-1:0];
        end
    end

    // Stage 7: square history line and the running window sum.
    t_word w_sqh_q [WINDOW_LENGTH];
    t_word r_sum;

    for (genvar k = 0; k < WINDOW_LENGTH; k++) begin : g_sqh
        if (k == 0) begin : g_head
            qpf_tap_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_load[7]),
                .i_d     (r_sq),
                .o_q     (w_sqh_q[k])
            );
        end else begin : g_body
            qpf_tap_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_load[7]),
                .i_d     (w_sqh_q[k-1]),
                .o_q     (w_sqh_q[k])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (w_load[7]) begin
            r_sum <= r_sum - w_sqh_q[WINDOW_LENGTH-1] + r_sq;
        end
    end

    // Stage 8: magnitude and sign of the window sum.
    t_uword r_mag;
    logic   r_neg8;

    always_ff @(posedge i_clk) begin
        if (w_load[8]) begin
            r_mag  <= r_sum[WORD_W-1] ? t_uword'(-r_sum) : t_uword'(r_sum);
            r_neg8 <= r_sum[WORD_W-1];
        end
    end

    // Stage 9: multiply by the reciprocal of the window length.
    logic [2*WORD_W-1:0] r_prod;
    t_uword              r_mag9;
    logic                r_neg9;

    always_ff @(posedge i_clk) begin
        if (w_load[9]) begin
            r_prod <= 64'(r_mag) * 64'(DIV_MAGIC);
            r_mag9 <= r_mag;
            r_neg9 <= r_neg8;
        end
    end

    // Stage 10: quotient estimate and its remainder.
    t_uword w_q_est;
    t_uword w_rem_full;
    t_uword r_q0;
    t_rem   r_rem;
    logic   r_neg10;

    assign w_q_est    = r_prod[MAGIC_SHIFT +: WORD_W];
    assign w_rem_full = r_mag9 - t_uword'(w_q_est * WINDOW_WORD);

    always_ff @(posedge i_clk) begin
        if (w_load[10]) begin
            r_q0    <= w_q_est;
            r_rem   <= w_rem_full[REM_W-1:0];
            r_neg10 <= r_neg9;
        end
    end

    // Stage 11: one correction step, sign restored, into the output register.
    t_uword w_q;
    t_word  r_out;

    assign w_q = r_q0 + t_uword'(r_rem >= t_rem'(WINDOW_LENGTH));

    always_ff @(posedge i_clk) begin
        if (w_load[11]) begin
            r_out <= r_neg10 ? -t_word'(w_q) : t_word'(w_q);
        end
    end

    assign o_result.valid      = r_vld[NUM_STAGES-1];
    assign o_result.integrated = r_out;

    // The remainder before correction stays below twice the window length.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[10] |-> ((REM_W+1)'(r_rem) < (REM_W+1)'(2 * WINDOW_LENGTH)))
        else $error("window division remainder out of range");

    // The magnitude of a 32-bit sum never exceeds 2^31.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[8] |-> (!r_mag[WORD_W-1] || (r_mag[WORD_W-2:0] == '0)))
        else $error("window sum magnitude out of range");

    // The pipeline is empty on the first cycle after reset.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> (r_vld == '0))
        else $error("pipeline not empty after reset");

    // A waiting result freezes every stage of the pipeline.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NUM_STAGES-1] && !o_result.ready) |=> $stable(r_vld) && $stable(r_sum))
        else $error("pipeline moved while the result was stalled");

endmodule

/* hw/rtl/qpf_tap_cell.sv */
// One cell of a history line: holds one word and passes it on at each shift.
module qpf_tap_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_shift,
    input  qpf_pkg::t_word i_d,
    output qpf_pkg::t_word o_q
);
    import qpf_pkg::*;

    t_word r_q;

    // Histories start at zero; a shift takes the neighbour's word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule
